FILE: sv/mtf_pkg.sv
// Shared constants, codes, types and address helpers of the move-to-front list.
`default_nettype none
package mtf_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ITEM_W      = 32;
    localparam int STORE_W     = (VALUE_WIDTH < ITEM_W) ? VALUE_WIDTH : ITEM_W;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_ACCESS = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD,
        S_SCAN,
        S_SHIFT,
        S_FRONT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_from_rd;
    } mem_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ITEM_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } rsp_t;

    // Physical slot of list position off, counted from the head slot.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: sv/mtf_ifs.sv
// Request and result channel interfaces of the move-to-front list.
`default_nettype none
interface mtf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface mtf_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_value;
    logic [4:0]  entry_count;

    modport source (output valid, output status, output out_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input out_value, input entry_count,
                    output ready);
endinterface
`default_nettype wire

FILE: sv/mtf_store.sv
// List storage: one-write, one-read memory with registered read and the shared comparator.
`default_nettype none
module mtf_store (
    input  wire logic                      clk,
    input  wire mtf_pkg::mem_cmd_t         cmd,
    input  wire logic [mtf_pkg::STORE_W-1:0] key,
    output logic [mtf_pkg::STORE_W-1:0]    rd_data,
    output logic                           match
);

    logic [mtf_pkg::STORE_W-1:0] mem [mtf_pkg::DEPTH];
    logic [mtf_pkg::STORE_W-1:0] rd_data_reg;

    // A shift step writes back the entry read in the previous cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_from_rd ? rd_data_reg : key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign match   = (rd_data_reg == key);

endmodule
`default_nettype wire

FILE: sv/mtf_ctrl.sv
// Sequencer: head pointer, fill count, scan and shift counters of the move-to-front list.
`default_nettype none
module mtf_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  in_type,
    input  wire logic [31:0]                 in_value,
    input  wire logic                        slot_free,
    output logic                             push,
    output mtf_pkg::rsp_t                    rsp,
    output mtf_pkg::mem_cmd_t                cmd,
    output logic [mtf_pkg::STORE_W-1:0]      key,
    input  wire logic [mtf_pkg::STORE_W-1:0] rd_data,
    input  wire logic                        match
);

    mtf_pkg::state_t state_reg, state_next;

    logic [mtf_pkg::IDX_W-1:0]   head_reg, head_next;
    logic [mtf_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [1:0]                  kind_reg, kind_next;
    logic [mtf_pkg::STORE_W-1:0] val_reg, val_next;
    logic [mtf_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                        pipe_vld_reg, pipe_vld_next;
    logic [mtf_pkg::CNT_W-1:0]   pipe_idx_reg, pipe_idx_next;
    logic                        rd_more_reg, rd_more_next;
    logic [1:0]                  status_reg, status_next;
    logic [mtf_pkg::STORE_W-1:0] outv_reg, outv_next;

    logic accept;
    logic hit;
    logic miss_end;
    logic is_full;
    logic is_empty;

    assign accept   = in_valid && in_ready;
    assign hit      = pipe_vld_reg && match;
    assign miss_end = pipe_vld_reg && !match
                      && (pipe_idx_reg == fill_reg - mtf_pkg::CNT_W'(1));
    assign is_full  = (fill_reg == mtf_pkg::CNT_W'(mtf_pkg::DEPTH));
    assign is_empty = (fill_reg == '0);
    assign key      = val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mtf_pkg::S_IDLE;
            head_reg     <= '0;
            fill_reg     <= '0;
            pipe_vld_reg <= 1'b0;
            rd_more_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            pipe_vld_reg <= pipe_vld_next;
            rd_more_reg  <= rd_more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        pipe_idx_reg <= pipe_idx_next;
        status_reg   <= status_next;
        outv_reg     <= outv_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = mtf_pkg::S_DECODE;
                end
            end
            mtf_pkg::S_DECODE:
            begin
                case (kind_reg)
                    mtf_pkg::REQ_REMOVE:
                    begin
                        state_next = is_empty ? mtf_pkg::S_DONE : mtf_pkg::S_HEAD;
                    end
                    mtf_pkg::REQ_ACCESS:
                    begin
                        state_next = is_empty ? mtf_pkg::S_DONE : mtf_pkg::S_SCAN;
                    end
                    default:
                    begin
                        state_next = mtf_pkg::S_DONE;
                    end
                endcase
            end
            mtf_pkg::S_HEAD:
            begin
                state_next = mtf_pkg::S_DONE;
            end
            mtf_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (pipe_idx_reg == '0) ? mtf_pkg::S_DONE : mtf_pkg::S_SHIFT;
                end
                else if (miss_end)
                begin
                    state_next = mtf_pkg::S_DONE;
                end
            end
            mtf_pkg::S_SHIFT:
            begin
                if (!rd_more_reg)
                begin
                    state_next = mtf_pkg::S_FRONT;
                end
            end
            mtf_pkg::S_FRONT:
            begin
                state_next = mtf_pkg::S_DONE;
            end
            mtf_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = mtf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mtf_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control and outputs.
    always_comb
    begin
        head_next     = head_reg;
        fill_next     = fill_reg;
        kind_next     = kind_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        rd_more_next  = rd_more_reg;
        status_next   = status_reg;
        outv_next     = outv_reg;
        in_ready      = 1'b0;
        push          = 1'b0;
        cmd           = '0;

        case (state_reg)
            mtf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    kind_next = in_type;
                    val_next  = mtf_pkg::STORE_W'(in_value);
                end
            end
            mtf_pkg::S_DECODE:
            begin
                status_next = mtf_pkg::STAT_OK;
                outv_next   = '0;
                idx_next    = '0;
                case (kind_reg)
                    mtf_pkg::REQ_INSERT:
                    begin
                        if (is_full)
                        begin
                            status_next = mtf_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = mtf_pkg::wrap_dec(head_reg);
                            head_next   = mtf_pkg::wrap_dec(head_reg);
                            fill_next   = fill_reg + mtf_pkg::CNT_W'(1);
                        end
                    end
                    mtf_pkg::REQ_REMOVE:
                    begin
                        if (is_empty)
                        begin
                            status_next = mtf_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = head_reg;
                        end
                    end
                    mtf_pkg::REQ_ACCESS:
                    begin
                        if (is_empty)
                        begin
                            status_next = mtf_pkg::STAT_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        status_next = mtf_pkg::STAT_OK;
                    end
                endcase
            end
            mtf_pkg::S_HEAD:
            begin
                outv_next = rd_data;
                head_next = mtf_pkg::wrap_add(head_reg, mtf_pkg::CNT_W'(1));
                fill_next = fill_reg - mtf_pkg::CNT_W'(1);
            end
            mtf_pkg::S_SCAN:
            begin
                // Reads run one position ahead of the comparison on the registered data.
                if (hit)
                begin
                    idx_next     = pipe_idx_reg - mtf_pkg::CNT_W'(1);
                    rd_more_next = 1'b1;
                end
                else if (miss_end)
                begin
                    status_next = mtf_pkg::STAT_NOTFOUND;
                end
                else if (idx_reg < fill_reg)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr   = mtf_pkg::wrap_add(head_reg, idx_reg);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg;
                    idx_next      = idx_reg + mtf_pkg::CNT_W'(1);
                end
            end
            mtf_pkg::S_SHIFT:
            begin
                // Each entry ahead of the hit is read, then written one place further back.
                if (rd_more_reg)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.rd_addr   = mtf_pkg::wrap_add(head_reg, idx_reg);
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg;
                    rd_more_next  = (idx_reg != '0);
                    idx_next      = idx_reg - mtf_pkg::CNT_W'(1);
                end
                if (pipe_vld_reg)
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_from_rd = 1'b1;
                    cmd.wr_addr    = mtf_pkg::wrap_add(head_reg,
                                                       pipe_idx_reg + mtf_pkg::CNT_W'(1));
                end
            end
            mtf_pkg::S_FRONT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = head_reg;
            end
            mtf_pkg::S_DONE:
            begin
                push = slot_free;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign rsp.status = status_reg;
    assign rsp.value  = mtf_pkg::ITEM_W'(outv_reg);
    assign rsp.count  = fill_reg;

endmodule
`default_nettype wire

FILE: sv/move_to_front_list.sv
// Move-to-front list: top level with the request and result channels and the result register.
//
// Requests arrive on req (req_type, item_value) and each gives exactly one result beat on
// rsp (status, out_value, entry_count). Insert puts a value at the front, remove-head pops
// the front value, and access moves the first matching entry to the front.
// The list sits in a one-read, one-write memory used as a ring, so insert and remove only
// move the head pointer: an insert passes through the decode state, a remove through the
// decode and head-read states, before its result goes to the result register.
// Access is limited by the single memory read port: a compare scan over the n held
// entries, a shift of the p entries ahead of a hit at position p, and one front write.
// The block takes one request at a time; req.ready is high only while it is idle.
// A finished result waits in the output register; the next request is accepted while it
// waits, and if rsp stalls the sequencer holds its next result until the register frees.
// Reset empties the list and clears the result valid flag; memory contents are not cleared.
`default_nettype none
module move_to_front_list (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mtf_req_if.sink    req,
    mtf_rsp_if.source  rsp
);

    mtf_pkg::mem_cmd_t           cmd;
    mtf_pkg::rsp_t               result;
    logic [mtf_pkg::STORE_W-1:0] key;
    logic [mtf_pkg::STORE_W-1:0] rd_data;
    logic                        match;
    logic                        push;
    logic                        slot_free;
    logic                        rsp_valid_reg, rsp_valid_next;
    mtf_pkg::rsp_t               rsp_data_reg, rsp_data_next;

    assign slot_free = !rsp_valid_reg || rsp.ready;

    mtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_type   (req.req_type),
        .in_value  (req.item_value),
        .slot_free (slot_free),
        .push      (push),
        .rsp       (result),
        .cmd       (cmd),
        .key       (key),
        .rd_data   (rd_data),
        .match     (match)
    );

    mtf_store u_store (
        .clk     (clk),
        .cmd     (cmd),
        .key     (key),
        .rd_data (rd_data),
        .match   (match)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (push)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = result;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_data_reg.status;
    assign rsp.out_value   = rsp_data_reg.value;
    assign rsp.entry_count = rsp_data_reg.count;

endmodule
`default_nettype wire
